FILE: hdl/vsc_pkg.sv
// Shared types and constants for the Vigenere stream cipher core.
package vsc_pkg;

  localparam int KeyMax     = 12;
  localparam int KeyIdxW    = 4;
  localparam int ShiftW     = 5;
  localparam int KeyShiftsW = KeyMax * ShiftW;
  localparam int CfgIdxW    = 2;
  localparam int DataW      = KeyShiftsW;

  localparam logic [CfgIdxW-1:0] CFG_KEY_SHIFTS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MODE       = 2'd2;

  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } cipher_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       lig;
  } fold_t;

endpackage

FILE: hdl/vsc_fold.sv
// Accent folding and ligature expansion of one message byte.
module vsc_fold (
  input  logic          [7:0] byte_i,
  input  logic                phase_i,
  output vsc_pkg::fold_t      fold_o
);

  always_comb begin
    fold_o.lig  = 1'b0;
    fold_o.data = byte_i;
    unique case (byte_i)
      8'd130, 8'd136, 8'd137, 8'd138:          fold_o.data = 8'h65;
      8'd131, 8'd132, 8'd133, 8'd134, 8'd160:  fold_o.data = 8'h61;
      8'd139, 8'd140, 8'd141, 8'd161:          fold_o.data = 8'h69;
      8'd147, 8'd148, 8'd149, 8'd162:          fold_o.data = 8'h6f;
      8'd129, 8'd150, 8'd151, 8'd163:          fold_o.data = 8'h75;
      8'd152:                                  fold_o.data = 8'h79;
      8'd135:                                  fold_o.data = 8'h63;
      8'd164:                                  fold_o.data = 8'h6e;
      8'd142, 8'd143:                          fold_o.data = 8'h41;
      8'd144:                                  fold_o.data = 8'h45;
      8'd153:                                  fold_o.data = 8'h4f;
      8'd154:                                  fold_o.data = 8'h55;
      8'd165:                                  fold_o.data = 8'h4e;
      8'd145: begin
        fold_o.lig  = 1'b1;
        fold_o.data = phase_i ? 8'h65 : 8'h61;
      end
      8'd146: begin
        fold_o.lig  = 1'b1;
        fold_o.data = phase_i ? 8'h45 : 8'h41;
      end
      default: fold_o.data = byte_i;
    endcase
  end

endmodule

FILE: hdl/vsc_shift.sv
// Vigenere shift of one folded byte: letters modulo 26, digits modulo 10.
module vsc_shift (
  input  logic                 [7:0]                 byte_i,
  input  logic                 [vsc_pkg::ShiftW-1:0] shift_i,
  input  vsc_pkg::cipher_mode_e                      mode_i,
  output logic                 [7:0]                 byte_o,
  output logic                                       sep_o
);

  logic       is_upper;
  logic       is_lower;
  logic       is_digit;
  logic [7:0] base;
  logic [6:0] modulus;
  logic [6:0] bias;
  logic [7:0] offs;
  logic [6:0] t;

  always_comb begin
    unique case (byte_i)
      8'h20, 8'h2c, 8'h2e, 8'h2f, 8'h5e, 8'h25, 8'h2a, 8'h24, 8'h7e, 8'h23,
      8'h7c, 8'h60, 8'h21, 8'h28, 8'h29, 8'h3d, 8'h2b, 8'h2d, 8'h5f, 8'h3a,
      8'h3f, 8'h3b, 8'h27, 8'h3c, 8'h3e, 8'h26, 8'h5b, 8'h5d, 8'h7b,
      8'h7d:   sep_o = 1'b1;
      default: sep_o = 1'b0;
    endcase
  end

  assign is_upper = (byte_i >= 8'h41) && (byte_i <= 8'h5a);
  assign is_lower = (byte_i >= 8'h61) && (byte_i <= 8'h7a);
  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);

  always_comb begin
    priority if (is_upper) begin
      base = 8'h41; modulus = 7'd26; bias = 7'd52;
    end else if (is_lower) begin
      base = 8'h61; modulus = 7'd26; bias = 7'd52;
    end else begin
      base = 8'h30; modulus = 7'd10; bias = 7'd40;
    end
    offs = byte_i - base;
    if (mode_i == vsc_pkg::MODE_DECRYPT) begin
      t = 7'(offs[4:0]) + bias - 7'(shift_i);
    end else begin
      t = 7'(offs[4:0]) + 7'(shift_i);
    end
    for (int i = 0; i < 4; i++) begin
      if (t >= modulus) begin
        t = t - modulus;
      end
    end
    if (is_upper || is_lower || is_digit) begin
      byte_o = base + 8'(t);
    end else begin
      byte_o = byte_i;
    end
  end

endmodule

FILE: hdl/vigenere_stream_cipher_core.sv
// Vigenere stream cipher core with code page 437/850 accent folding.
// An accepted byte is held in the input register, folded and shifted, and captured in the result register.
// One input byte per cycle while the output is not stalled; a ligature byte holds the
// input register for two result beats, one per folded letter.
// Reset clears key position, valid flags and registers to key 0, length 1, encrypt.
module vigenere_stream_cipher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vsc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vsc_pkg::DataW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          message_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          last_of_run_o
);

  logic [vsc_pkg::KeyShiftsW-1:0] key_shifts_q;
  logic [vsc_pkg::KeyIdxW-1:0]    key_length_q;
  vsc_pkg::cipher_mode_e          mode_q;
  logic [vsc_pkg::KeyIdxW-1:0]    key_pos_q, key_pos_d;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       start_q;
  logic       phase_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       last_q;

  logic                        in_accept;
  logic                        advance;
  logic                        done;
  vsc_pkg::fold_t              fold;
  logic [7:0]                  shifted;
  logic                        sep;
  logic [vsc_pkg::KeyIdxW-1:0] len_eff;
  logic [vsc_pkg::KeyIdxW-1:0] pos_eff;
  logic [vsc_pkg::KeyIdxW-1:0] idx;
  logic [vsc_pkg::KeyIdxW-1:0] idx_inc;
  logic [vsc_pkg::ShiftW-1:0]  shift_tbl [vsc_pkg::KeyMax];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_shifts_q <= '0;
      key_length_q <= vsc_pkg::KeyIdxW'(1);
      mode_q       <= vsc_pkg::MODE_ENCRYPT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vsc_pkg::CFG_KEY_SHIFTS: key_shifts_q <= cfg_wdata_i[vsc_pkg::KeyShiftsW-1:0];
        vsc_pkg::CFG_KEY_LENGTH: key_length_q <= cfg_wdata_i[vsc_pkg::KeyIdxW-1:0];
        vsc_pkg::CFG_MODE:       mode_q <= vsc_pkg::cipher_mode_e'(cfg_wdata_i[0]);
        default: ;
      endcase
    end
  end

  vsc_fold u_fold (
    .byte_i  (in_byte_q),
    .phase_i (phase_q),
    .fold_o  (fold)
  );

  always_comb begin
    for (int i = 0; i < vsc_pkg::KeyMax; i++) begin
      shift_tbl[i] = key_shifts_q[i*vsc_pkg::ShiftW +: vsc_pkg::ShiftW];
    end
  end

  always_comb begin
    if (key_length_q == '0) begin
      len_eff = vsc_pkg::KeyIdxW'(1);
    end else if (key_length_q > vsc_pkg::KeyIdxW'(vsc_pkg::KeyMax)) begin
      len_eff = vsc_pkg::KeyIdxW'(vsc_pkg::KeyMax);
    end else begin
      len_eff = key_length_q;
    end
    pos_eff = (start_q && !phase_q) ? '0 : key_pos_q;
    idx     = (pos_eff >= len_eff) ? '0 : pos_eff;
    idx_inc = idx + vsc_pkg::KeyIdxW'(1);
    if (sep) begin
      key_pos_d = pos_eff;
    end else begin
      key_pos_d = (idx_inc >= len_eff) ? '0 : idx_inc;
    end
  end

  vsc_shift u_shift (
    .byte_i  (fold.data),
    .shift_i (shift_tbl[idx]),
    .mode_i  (mode_q),
    .byte_o  (shifted),
    .sep_o   (sep)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign done       = advance && (!fold.lig || phase_q);
  assign in_stall_o = in_valid_q && !done;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= 1'b0;
      key_pos_q  <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (done) begin
        in_valid_q <= 1'b0;
      end
      if (done) begin
        phase_q <= 1'b0;
      end else if (advance) begin
        phase_q <= 1'b1;
      end
      if (advance) begin
        key_pos_q <= key_pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
      start_q   <= message_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= shifted;
      last_q     <= done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;

  a_key_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_pos_q < vsc_pkg::KeyIdxW'(vsc_pkg::KeyMax))
    else $error("key position out of range");

  a_phase_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> in_valid_q)
    else $error("second ligature beat pending without an item");

  a_first_beat_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && fold.lig && !phase_q |=> out_valid_q && !last_q && phase_q)
    else $error("first ligature beat marked as last");

  a_open_run_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !last_q |-> phase_q)
    else $error("open run without pending second beat");

endmodule
